@@ hw/rtl/box_blur_3x3_rgb_unit_macros.svh @@
// box_blur_3x3_rgb_unit_macros.svh: assertion macros for the box blur unit
// expects the using module to have signals named clock and reset
// assertions drop out when SYNTHESIS is defined
`ifndef BOX_BLUR_3X3_RGB_UNIT_MACROS_SVH
`define BOX_BLUR_3X3_RGB_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define BBR_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("bbr assertion failed");

// antecedent in one cycle implies consequent in the next
`define BBR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bbr assertion failed");

`else

`define BBR_ASSERT(label, prop)
`define BBR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ hw/rtl/bbr_pkg.sv @@
// bbr_pkg: widths, codes, types and helper functions of the box blur unit
// used by every module of the block; depends on nothing
`default_nettype none

package bbr_pkg;

   // geometry
   localparam int MAX_WIDTH   = 2048;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = 16;
   localparam int CFG_WIDTH_W = 12;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = CSR_IDX_W'(1);
   localparam int FRAME_WIDTH_RESET  = 640;
   localparam int FRAME_HEIGHT_RESET = 480;

   // pixel and arithmetic widths
   localparam int CHAN_W   = 8;
   localparam int NUM_CHAN = 3;
   localparam int PIX_W    = NUM_CHAN * CHAN_W;
   localparam int COLSUM_W = 10;   // three channel values
   localparam int SUM_W    = 12;   // nine channel values plus rounding offset
   localparam int RECIP_W  = 15;
   localparam int RECIP_SHIFT = 16;
   localparam int PROD_W   = SUM_W + RECIP_W;

   // rounded mean: floor((S + n/2) / n), as (S + ofs) * recip >> RECIP_SHIFT
   localparam logic [SUM_W-1:0]   OFS_4   = SUM_W'(2);
   localparam logic [SUM_W-1:0]   OFS_6   = SUM_W'(3);
   localparam logic [SUM_W-1:0]   OFS_9   = SUM_W'(4);
   localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(16384);
   localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(10923);
   localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(7282);

   typedef enum logic [1:0] {
      DIV_BY_4,
      DIV_BY_6,
      DIV_BY_9
   } div_type;

   // one live request as issued by the position control
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [COL_W-1:0] col;
      logic             emit;
      logic             skip_left;
      logic             skip_right;
      logic             skip_top;
      logic             skip_bottom;
      logic             last;
   } item_type;

   // masked column sums of one output window, [column][channel]
   typedef struct packed {
      logic [2:0][NUM_CHAN-1:0][COLSUM_W-1:0] col_sum;
      logic    skip_left;
      logic    skip_right;
      div_type div;
      logic    last;
   } colsum_type;

   // last column index for a programmed width, clamped to [2, MAX_WIDTH]
   function automatic logic [COL_W-1:0] width_last(input logic [CFG_WIDTH_W-1:0] v);
      int w;
      w = int'(v);
      if (w < 2) begin
         w = 2;
      end else if (w > MAX_WIDTH) begin
         w = MAX_WIDTH;
      end
      return COL_W'(w - 1);
   endfunction

   // last row index for a programmed height, clamped to at least 2
   function automatic logic [ROW_W-1:0] height_last(input logic [ROW_W-1:0] v);
      return (v < ROW_W'(2)) ? ROW_W'(1) : v - ROW_W'(1);
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bbr_ctrl.sv @@
// bbr_ctrl: frame size registers, input and output raster positions, drain flag
// issues one item per live request; uses bbr_pkg and the assertion macros
`default_nettype none
`include "box_blur_3x3_rgb_unit_macros.svh"

module bbr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic [bbr_pkg::PIX_W-1:0]     req_tdata,
   input  logic                          req_tuser,
   input  logic                          item_ready,
   output logic                          item_valid,
   output bbr_pkg::item_type             item,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bbr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bbr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bbr_pkg::*;

   logic [COL_W-1:0] w_last_ff, w_last_in;
   logic [ROW_W-1:0] h_last_ff, h_last_in;
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic             draining_ff, draining_in;
   logic             csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // flush is live only while draining, a pixel only while not
   assign item_valid = req_tvalid && item_ready && (req_tuser == draining_ff);

   // item for the current positions
   always_comb begin
      item.pixel       = req_tuser ? '0 : req_tdata;
      item.col         = in_col_ff;
      item.emit        = draining_ff || (|in_row_ff[ROW_W-1:1])
                         || (in_row_ff == ROW_W'(1) && in_col_ff != '0);
      item.skip_left   = (out_col_ff == '0);
      item.skip_right  = (out_col_ff == w_last_ff);
      item.skip_top    = (out_row_ff == '0);
      item.skip_bottom = (out_row_ff == h_last_ff);
      item.last        = item.emit && item.skip_right && item.skip_bottom;
   end

   // next positions
   always_comb begin
      w_last_in   = w_last_ff;
      h_last_in   = h_last_ff;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      draining_in = draining_ff;

      if (item_valid) begin
         // output position advances with each result
         if (item.emit) begin
            if (item.skip_right) begin
               out_col_in = '0;
               out_row_in = out_row_ff + ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
         // input position; row stays put while draining
         if (in_col_ff == w_last_ff) begin
            in_col_in = '0;
            if (!draining_ff) begin
               if (in_row_ff == h_last_ff) begin
                  draining_in = 1'b1;
                  in_row_in   = '0;
               end else begin
                  in_row_in = in_row_ff + ROW_W'(1);
               end
            end
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
         // frame done
         if (item.last) begin
            in_col_in   = '0;
            in_row_in   = '0;
            out_col_in  = '0;
            out_row_in  = '0;
            draining_in = 1'b0;
         end
      end

      // a write to frame width or height restarts the frame
      if (csr_write) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               w_last_in   = width_last(csr_wdata[CFG_WIDTH_W-1:0]);
               in_col_in   = '0;
               in_row_in   = '0;
               out_col_in  = '0;
               out_row_in  = '0;
               draining_in = 1'b0;
            end
            CSR_FRAME_HEIGHT: begin
               h_last_in   = height_last(csr_wdata[ROW_W-1:0]);
               in_col_in   = '0;
               in_row_in   = '0;
               out_col_in  = '0;
               out_row_in  = '0;
               draining_in = 1'b0;
            end
            default: begin
               w_last_in = w_last_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff   <= width_last(CFG_WIDTH_W'(FRAME_WIDTH_RESET));
         h_last_ff   <= height_last(ROW_W'(FRAME_HEIGHT_RESET));
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         draining_ff <= 1'b0;
      end else begin
         w_last_ff   <= w_last_in;
         h_last_ff   <= h_last_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         draining_ff <= draining_in;
      end
   end

   // checks
   `BBR_ASSERT(a_drain_row_zero, !draining_ff || (in_row_ff == '0))
   `BBR_ASSERT(a_cols_in_frame, (in_col_ff <= w_last_ff) && (out_col_ff <= w_last_ff))
   `BBR_ASSERT(a_last_when_draining, !(item_valid && item.last) || draining_ff)
   `BBR_ASSERT_NEXT(a_last_restarts, item_valid && item.last,
      in_col_ff == '0 && out_row_ff == '0 && !draining_ff)

endmodule

`default_nettype wire

@@ hw/rtl/bbr_window.sv @@
// bbr_window: two-row line store memory, 3x3 window and masked column sums
// read at request, write back one stage later; uses bbr_pkg
`default_nettype none

module bbr_window (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  bbr_pkg::item_type    item,
   output logic                 item_ready,
   output logic                 blk_valid,
   output bbr_pkg::colsum_type  blk,
   input  logic                 blk_ready
);
   import bbr_pkg::*;

   // entry: upper row in the high half, middle row in the low half
   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_ff;

   logic       a_valid_ff, a_valid_in;
   item_type   a_item_ff;
   logic       a_adv;
   logic       b_valid_ff, b_valid_in;
   colsum_type b_blk_ff, b_blk_in;
   logic       b_free;

   logic [PIX_W-1:0] win_new_ff [3];
   logic [PIX_W-1:0] win_old_ff [3];
   logic [PIX_W-1:0] cur [3];
   logic [PIX_W-1:0] col_pix [3][3];
   logic             cols2, rows2;

   // stage handshakes
   assign b_free     = !b_valid_ff || blk_ready;
   assign a_adv      = a_valid_ff && (!a_item_ff.emit || b_free);
   assign item_ready = !a_valid_ff || a_adv;
   assign a_valid_in = item_valid ? 1'b1 : (a_adv ? 1'b0 : a_valid_ff);
   assign b_valid_in = (a_adv && a_item_ff.emit) ? 1'b1 : (blk_ready ? 1'b0 : b_valid_ff);

   // line store: read at request, shift rows and write back as the item leaves
   always_ff @(posedge clock) begin
      if (item_valid) begin
         rd_ff <= line_mem[item.col];
      end
      if (a_adv) begin
         line_mem[a_item_ff.col] <= {rd_ff[PIX_W-1:0], a_item_ff.pixel};
      end
   end

   // current column, top to bottom
   assign cur[0] = rd_ff[2*PIX_W-1:PIX_W];
   assign cur[1] = rd_ff[PIX_W-1:0];
   assign cur[2] = a_item_ff.pixel;

   // masked column sums and divisor for the output window
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         col_pix[0][r] = win_old_ff[r];
         col_pix[1][r] = win_new_ff[r];
         col_pix[2][r] = cur[r];
      end
      for (int c = 0; c < 3; c++) begin
         for (int k = 0; k < NUM_CHAN; k++) begin
            b_blk_in.col_sum[c][k] =
               (a_item_ff.skip_top ? '0 : COLSUM_W'(col_pix[c][0][k*CHAN_W +: CHAN_W]))
               + COLSUM_W'(col_pix[c][1][k*CHAN_W +: CHAN_W])
               + (a_item_ff.skip_bottom ? '0 : COLSUM_W'(col_pix[c][2][k*CHAN_W +: CHAN_W]));
         end
      end
      cols2 = a_item_ff.skip_left || a_item_ff.skip_right;
      rows2 = a_item_ff.skip_top || a_item_ff.skip_bottom;
      if (cols2 && rows2) begin
         b_blk_in.div = DIV_BY_4;
      end else if (cols2 || rows2) begin
         b_blk_in.div = DIV_BY_6;
      end else begin
         b_blk_in.div = DIV_BY_9;
      end
      b_blk_in.skip_left  = a_item_ff.skip_left;
      b_blk_in.skip_right = a_item_ff.skip_right;
      b_blk_in.last       = a_item_ff.last;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (item_valid) begin
         a_item_ff <= item;
      end
      if (a_adv) begin
         for (int r = 0; r < 3; r++) begin
            win_old_ff[r] <= win_new_ff[r];
            win_new_ff[r] <= cur[r];
         end
      end
      if (a_adv && a_item_ff.emit) begin
         b_blk_ff <= b_blk_in;
      end
   end

   assign blk_valid = b_valid_ff;
   assign blk       = b_blk_ff;

endmodule

`default_nettype wire

@@ hw/rtl/bbr_avg.sv @@
// bbr_avg: window sum, rounded division by 4, 6 or 9, and the result register
// reciprocal multiply with offset; uses bbr_pkg
`default_nettype none

module bbr_avg (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       blk_valid,
   input  bbr_pkg::colsum_type        blk,
   output logic                       blk_ready,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [bbr_pkg::PIX_W-1:0]  rsp_tdata,
   output logic                       rsp_tlast
);
   import bbr_pkg::*;

   logic               c_valid_ff, c_valid_in;
   logic [SUM_W-1:0]   c_sum_ff [NUM_CHAN];
   logic [SUM_W-1:0]   c_sum_in [NUM_CHAN];
   logic [RECIP_W-1:0] c_recip_ff, c_recip_in;
   logic               c_last_ff;
   logic [SUM_W-1:0]   ofs;
   logic               c_adv;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]   rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff;
   logic [PROD_W-1:0]  prod [NUM_CHAN];

   // handshakes
   assign c_adv        = c_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign blk_ready    = !c_valid_ff || c_adv;
   assign c_valid_in   = blk_valid ? 1'b1 : (c_adv ? 1'b0 : c_valid_ff);
   assign rsp_valid_in = c_adv ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // window sum with rounding offset, reciprocal by divisor
   always_comb begin
      case (blk.div)
         DIV_BY_4: begin
            ofs        = OFS_4;
            c_recip_in = RECIP_4;
         end
         DIV_BY_6: begin
            ofs        = OFS_6;
            c_recip_in = RECIP_6;
         end
         default: begin
            ofs        = OFS_9;
            c_recip_in = RECIP_9;
         end
      endcase
      for (int k = 0; k < NUM_CHAN; k++) begin
         c_sum_in[k] = (blk.skip_left ? '0 : SUM_W'(blk.col_sum[0][k]))
                       + SUM_W'(blk.col_sum[1][k])
                       + (blk.skip_right ? '0 : SUM_W'(blk.col_sum[2][k]))
                       + ofs;
      end
   end

   // multiply and take the quotient bits
   always_comb begin
      for (int k = 0; k < NUM_CHAN; k++) begin
         prod[k] = PROD_W'(c_sum_ff[k]) * PROD_W'(c_recip_ff);
         rsp_data_in[k*CHAN_W +: CHAN_W] = prod[k][RECIP_SHIFT +: CHAN_W];
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         c_valid_ff   <= c_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (blk_valid && blk_ready) begin
         for (int k = 0; k < NUM_CHAN; k++) begin
            c_sum_ff[k] <= c_sum_in[k];
         end
         c_recip_ff <= c_recip_in;
         c_last_ff  <= blk.last;
      end
      if (c_adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= c_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

@@ hw/rtl/box_blur_3x3_rgb_unit.sv @@
// box_blur_3x3_rgb_unit: top level of the streaming 3x3 RGB box blur
// instantiates bbr_ctrl, bbr_window and bbr_avg; uses bbr_pkg

// Takes one request per clock when the result side keeps up: the line store is
// a single memory of MAX_WIDTH entries, each holding the two previous rows of
// one column, read once when a request is taken and written back once as it
// moves on, so a steady stream runs at one pixel per cycle. A pixel request
// gives the blurred pixel width+1 raster positions behind it; after the last
// pixel of a frame, width+1 flush requests (tuser high) drain the rest, the
// final one with tlast. Results pass registers a, b, c and the result register
// to rsp; stalls on rsp back up through a four-register pipeline whose empty
// slots still take requests. The line store is never cleared, so there is no
// wait after reset. Configuration writes are always ready and belong only where
// the block is idle; width and height writes restart the frame.
`default_nettype none

module box_blur_3x3_rgb_unit (
   input  logic                           clock,
   input  logic                           reset,
   // request: tdata = red_in[7:0], green_in[15:8], blue_in[23:16]
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [bbr_pkg::PIX_W-1:0]      req_tdata,
   input  logic                           req_tuser,   // mode[0]
   // result: tdata = red_out[7:0], green_out[15:8], blue_out[23:16]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bbr_pkg::PIX_W-1:0]      rsp_tdata,
   output logic                           rsp_tlast,
   // register writes: index 0 frame_width, 1 frame_height
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bbr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bbr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bbr_pkg::*;

   logic       item_valid;
   item_type   item;
   logic       item_ready;
   logic       blk_valid;
   colsum_type blk;
   logic       blk_ready;

   assign req_tready = item_ready;

   // positions and frame registers
   bbr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_ready (item_ready),
      .item_valid (item_valid),
      .item       (item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // line store and window
   bbr_window u_window (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready),
      .blk_valid  (blk_valid),
      .blk        (blk),
      .blk_ready  (blk_ready)
   );

   // averaging and result register
   bbr_avg u_avg (
      .clock      (clock),
      .reset      (reset),
      .blk_valid  (blk_valid),
      .blk        (blk),
      .blk_ready  (blk_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ test/tb.sv @@
// tb: self-checking bench for box_blur_3x3_rgb_unit, the streaming 3x3 rgb box blur
// drives a directed table, then random frames; results checked against a local blur model or the table's own
// expectations; depends on bbr_pkg and the rtl of box_blur_3x3_rgb_unit
`timescale 1ns / 1ps

module tb;
   import bbr_pkg::*;

   localparam int ITEMS_TARGET = 700;
   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int REPORT_MAX   = 10;

   // register indexes past the end of the register list
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = CSR_IDX_W'(3);

   // handy pixels, red in the low byte
   localparam logic [PIX_W-1:0] BLACK = 24'h000000;
   localparam logic [PIX_W-1:0] WHITE = 24'hFFFFFF;
   localparam logic [PIX_W-1:0] RED   = 24'h0000FF;
   localparam logic [PIX_W-1:0] GREEN = 24'h00FF00;
   localparam logic [PIX_W-1:0] BLUE  = 24'hFF0000;
   localparam logic [PIX_W-1:0] GREY  = 24'h808080;

   typedef enum logic [1:0] {
      OP_PIXEL,
      OP_FLUSH,
      OP_CSR
   } stim_op_e;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_THREE_OF_FOUR,
      RX_SPARSE
   } rx_style_e;

   // one blurred pixel, packed like rsp_tdata with the frame end on top
   typedef struct packed {
      logic       last;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } blur_out_t;

   // directed row: idx only matters for OP_CSR; given rows carry their own expectation
   typedef struct packed {
      stim_op_e               op;
      logic [CSR_IDX_W-1:0]   idx;
      logic [PIX_W-1:0]       data;
      logic                   given;
      logic                   hit;
      logic [PIX_W-1:0]       exp_pix;
      logic                   exp_last;
   } stim_row_t;

   localparam int DIR_ROWS = 31;

   stim_row_t directed_tab [DIR_ROWS] = '{
      // 2x2 frame, every result is the plain mean of four pixels
      '{OP_CSR,   CSR_FRAME_WIDTH,  24'h000002, 1'b0, 1'b0, BLACK, 1'b0},
      '{OP_CSR,   CSR_FRAME_HEIGHT, 24'h000002, 1'b0, 1'b0, BLACK, 1'b0},
      // flush with nothing to drain
      '{OP_FLUSH, CSR_FRAME_WIDTH,  BLACK,      1'b1, 1'b0, BLACK, 1'b0},
      '{OP_PIXEL, CSR_FRAME_WIDTH,  WHITE,      1'b1, 1'b0, BLACK, 1'b0},
      // flush in the middle of a frame
      '{OP_FLUSH, CSR_FRAME_WIDTH,  WHITE,      1'b1, 1'b0, BLACK, 1'b0},
      '{OP_PIXEL, CSR_FRAME_WIDTH,  WHITE,      1'b1, 1'b0, BLACK, 1'b0},
      '{OP_PIXEL, CSR_FRAME_WIDTH,  WHITE,      1'b1, 1'b0, BLACK, 1'b0},
      '{OP_PIXEL, CSR_FRAME_WIDTH,  WHITE,      1'b1, 1'b1, WHITE, 1'b0},
      // pixel sent while the frame drains
      '{OP_PIXEL, CSR_FRAME_WIDTH,  24'h123456, 1'b1, 1'b0, BLACK, 1'b0},
      '{OP_FLUSH, CSR_FRAME_WIDTH,  BLACK,      1'b1, 1'b1, WHITE, 1'b0},
      '{OP_FLUSH, CSR_FRAME_WIDTH,  BLACK,      1'b1, 1'b1, WHITE, 1'b0},
      '{OP_FLUSH, CSR_FRAME_WIDTH,  BLACK,      1'b1, 1'b1, WHITE, 1'b1},
      // primaries plus white: every channel sums to 510, rounds up to 128
      '{OP_PIXEL, CSR_FRAME_WIDTH,  RED,        1'b1, 1'b0, BLACK, 1'b0},
      '{OP_PIXEL, CSR_FRAME_WIDTH,  GREEN,      1'b1, 1'b0, BLACK, 1'b0},
      '{OP_PIXEL, CSR_FRAME_WIDTH,  BLUE,       1'b1, 1'b0, BLACK, 1'b0},
      '{OP_PIXEL, CSR_FRAME_WIDTH,  WHITE,      1'b1, 1'b1, GREY,  1'b0},
      '{OP_FLUSH, CSR_FRAME_WIDTH,  BLACK,      1'b1, 1'b1, GREY,  1'b0},
      '{OP_FLUSH, CSR_FRAME_WIDTH,  BLACK,      1'b1, 1'b1, GREY,  1'b0},
      '{OP_FLUSH, CSR_FRAME_WIDTH,  BLACK,      1'b1, 1'b1, GREY,  1'b1},
      // sizes below the minimum, upper width bits set, writes to unused indexes
      '{OP_CSR,   CSR_FRAME_WIDTH,  24'h00F000, 1'b0, 1'b0, BLACK, 1'b0},
      '{OP_CSR,   CSR_FRAME_HEIGHT, 24'h000001, 1'b0, 1'b0, BLACK, 1'b0},
      '{OP_CSR,   CSR_SPARE_2,      24'h00FFFF, 1'b0, 1'b0, BLACK, 1'b0},
      '{OP_CSR,   CSR_SPARE_3,      24'h000000, 1'b0, 1'b0, BLACK, 1'b0},
      // rounding near one half
      '{OP_PIXEL, CSR_FRAME_WIDTH,  24'h030102, 1'b0, 1'b0, BLACK, 1'b0},
      '{OP_PIXEL, CSR_FRAME_WIDTH,  BLACK,      1'b0, 1'b0, BLACK, 1'b0},
      '{OP_PIXEL, CSR_FRAME_WIDTH,  BLACK,      1'b0, 1'b0, BLACK, 1'b0},
      '{OP_PIXEL, CSR_FRAME_WIDTH,  BLACK,      1'b0, 1'b0, BLACK, 1'b0},
      '{OP_FLUSH, CSR_FRAME_WIDTH,  BLACK,      1'b0, 1'b0, BLACK, 1'b0},
      '{OP_FLUSH, CSR_FRAME_WIDTH,  BLACK,      1'b0, 1'b0, BLACK, 1'b0},
      '{OP_FLUSH, CSR_FRAME_WIDTH,  BLACK,      1'b0, 1'b0, BLACK, 1'b0},
      '{OP_FLUSH, CSR_FRAME_WIDTH,  BLACK,      1'b0, 1'b0, BLACK, 1'b0}
   };

   // dut ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [PIX_W-1:0]      rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // blur model state
   logic [PIX_W-1:0] rows_above [MAX_WIDTH];
   logic [PIX_W-1:0] rows_mid [MAX_WIDTH];
   logic [PIX_W-1:0] win_cols [6];   // [0..2] newer column, [3..5] older; top, mid, bottom
   int unsigned      cfg_w_raw = FRAME_WIDTH_RESET;
   int unsigned      cfg_h_raw = FRAME_HEIGHT_RESET;
   int unsigned      in_x, in_y, out_x, out_y;
   bit               flushing;

   blur_out_t blur_due_q [$];
   blur_out_t due;

   // bookkeeping
   int   fail_count = 0;
   int   results_seen = 0;
   int   live_items = 0;
   int   bulk_items = 0;
   int   burst_left = 0;
   int   cycle_count = 0;
   int   frames = 0;
   int   frames_cut = 0;
   int   csr_writes = 0;
   int   hold_asks = 0;
   int   hold_seen = 0;
   int   hold_left = 0;
   int   style_left = 0;
   rx_style_e rx_style = RX_OPEN;

   // random phase variables
   int          phase, pixels, steps, stop_at, pos, before_bulk;
   bit          cut, keep_cfg, phase_done;
   logic [11:0] w_raw;
   logic [15:0] h_raw;

   box_blur_3x3_rgb_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 100 MHz clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // frame width and height as the block uses them
   function automatic int unsigned used_width();
      if (cfg_w_raw < 2) return 2;
      if (cfg_w_raw > MAX_WIDTH) return MAX_WIDTH;
      return cfg_w_raw;
   endfunction

   function automatic int unsigned used_height();
      return (cfg_h_raw < 2) ? 2 : cfg_h_raw;
   endfunction

   // drop the frame in progress; line stores are kept
   function automatic void frame_restart();
      foreach (win_cols[i]) win_cols[i] = '0;
      in_x = 0;
      in_y = 0;
      out_x = 0;
      out_y = 0;
      flushing = 1'b0;
   endfunction

   // advance the blur model by one request; returns 1 when a result comes out
   function automatic bit blur_predict(input bit flush, input logic [PIX_W-1:0] pix,
                                       output blur_out_t res, output bit taken);
      int unsigned      w, h, col, sum, n, c_lo, c_hi, r_lo, r_hi;
      int               c, r, k;
      logic [PIX_W-1:0] cur [3];
      logic [PIX_W-1:0] win [3][3];
      logic [PIX_W-1:0] mean_px;
      bit               emit, last;
      w = used_width();
      h = used_height();
      res = '0;
      last = 1'b0;
      mean_px = '0;
      taken = (flush == flushing);
      if (!taken) return 1'b0;
      emit = flushing || in_y >= 2 || (in_y == 1 && in_x >= 1);

      // line stores shift down one row at this column
      col = in_x;
      cur[0] = rows_above[col];
      cur[1] = rows_mid[col];
      cur[2] = flush ? '0 : pix;
      rows_above[col] = cur[1];
      rows_mid[col] = cur[2];

      // three-column window: older, newer, current
      for (r = 0; r < 3; r++) begin
         win[0][r] = win_cols[3 + r];
         win[1][r] = win_cols[r];
         win[2][r] = cur[r];
         win_cols[3 + r] = win_cols[r];
         win_cols[r] = cur[r];
      end

      // rounded mean over the in-frame part of the window
      if (emit) begin
         c_lo = (out_x == 0) ? 1 : 0;
         c_hi = (out_x + 1 >= w) ? 1 : 2;
         r_lo = (out_y == 0) ? 1 : 0;
         r_hi = (out_y + 1 >= h) ? 1 : 2;
         n = (c_hi - c_lo + 1) * (r_hi - r_lo + 1);
         for (k = 0; k < 3; k++) begin
            sum = 0;
            for (c = c_lo; c <= c_hi; c++)
               for (r = r_lo; r <= r_hi; r++)
                  sum += win[c][r][8*k +: 8];
            mean_px[8*k +: 8] = 8'((2 * sum + n) / (2 * n));
         end
         last = (out_y + 1 >= h) && (out_x + 1 >= w);
         res = {last, mean_px};
         if (out_x + 1 >= w) begin
            out_x = 0;
            out_y = (out_y + 1) & 32'hFFFF;
         end else begin
            out_x++;
         end
      end

      // input position; the row count stops once draining
      if (in_x + 1 >= w) begin
         in_x = 0;
         if (!flushing) begin
            if (in_y + 1 >= h) begin
               flushing = 1'b1;
               in_y = 0;
            end else begin
               in_y++;
            end
         end
      end else begin
         in_x++;
      end

      if (last) frame_restart();
      return emit;
   endfunction

   // offer one request in bursts; given rows supply their own expectation
   task automatic send_req(input bit flush, input logic [PIX_W-1:0] pix, input bit given,
                           input bit given_hit, input blur_out_t given_res);
      blur_out_t res;
      bit        taken, emit;
      int        gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tuser <= flush;
      req_tdata <= pix;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      if (burst_left == 0) req_tvalid <= 1'b0;
      emit = blur_predict(flush, pix, res, taken);
      if (given) begin
         if (given_hit) blur_due_q.push_back(given_res);
      end else if (emit) begin
         blur_due_q.push_back(res);
      end
      if (taken) live_items++;
   endtask

   // stop requests, let every result come out, then give the block time to settle
   task automatic wait_idle();
      if (burst_left != 0) req_tvalid <= 1'b0;
      burst_left = 0;
      while (blur_due_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write, only with the block idle
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH: begin
            cfg_w_raw = value[CFG_WIDTH_W-1:0];
            frame_restart();
         end
         CSR_FRAME_HEIGHT: begin
            cfg_h_raw = value;
            frame_restart();
         end
         default: ;
      endcase
      csr_writes++;
   endtask

   // result side: long hold on request, otherwise a changing stall pattern
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (style_left == 0) begin
            rx_style = rx_style_e'($urandom_range(0, 3));
            style_left = $urandom_range(32, 256);
         end
         style_left--;
         case (rx_style)
            RX_OPEN:          rsp_tready <= 1'b1;
            RX_COIN:          rsp_tready <= 1'($urandom_range(0, 1));
            RX_THREE_OF_FOUR: rsp_tready <= (style_left % 4) != 0;
            default:          rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (blur_due_q.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display("unexpected result %0d: data %h last %b", results_seen, rsp_tdata,
                        rsp_tlast);
         end else begin
            due = blur_due_q.pop_front();
            if (rsp_tdata[7:0] !== due.red || rsp_tdata[15:8] !== due.green ||
                rsp_tdata[23:16] !== due.blue || rsp_tlast !== due.last) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("result %0d: expected r %0d g %0d b %0d last %0d, got r %0d g %0d b %0d last %0d",
                           results_seen, due.red, due.green, due.blue, due.last,
                           rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tlast);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", blur_due_q.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // stimulus
   initial begin
      foreach (rows_above[i]) begin
         rows_above[i] = '0;
         rows_mid[i] = '0;
      end
      frame_restart();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_tab[i]) begin
         if (directed_tab[i].op == OP_CSR)
            csr_write(directed_tab[i].idx, directed_tab[i].data[CSR_DATA_W-1:0]);
         else
            send_req(directed_tab[i].op == OP_FLUSH, directed_tab[i].data, directed_tab[i].given,
                     directed_tab[i].hit, {directed_tab[i].exp_last, directed_tab[i].exp_pix});
      end

      // random frames: mostly complete frames with stray requests mixed in, some cut short
      phase = 0;
      phase_done = 1'b0;
      while (live_items - bulk_items < ITEMS_TARGET) begin
         cut = 1'b0;
         keep_cfg = 1'b0;
         if (phase == 1) begin
            w_raw = 12'd16;
            h_raw = 16'd8;
         end else if (phase == 3) begin
            w_raw = 12'hFFF;
            h_raw = 16'd2;
         end else if (phase == 5) begin
            w_raw = 12'($urandom_range(2, 5));
            h_raw = 16'hFFFF;
            cut = 1'b1;
         end else begin
            keep_cfg = phase_done && ($urandom_range(0, 2) == 0);
            w_raw = 12'($urandom_range(0, 12));
            h_raw = 16'($urandom_range(0, 7));
            cut = ($urandom_range(0, 5) == 0);
         end
         if (!keep_cfg) begin
            csr_write(CSR_FRAME_WIDTH, {4'($urandom), w_raw});
            csr_write(CSR_FRAME_HEIGHT, h_raw);
         end

         pixels = used_width() * used_height();
         steps = pixels + used_width() + 1;
         if (phase == 5)
            stop_at = 3 * used_width() + $urandom_range(0, used_width() - 1);
         else if (cut)
            stop_at = $urandom_range(0, steps - 1);
         else
            stop_at = steps;

         // receiver backs off while the sender keeps pushing
         if (phase == 1) hold_asks <= hold_asks + 1;
         before_bulk = live_items;

         for (pos = 0; pos < stop_at; pos++) begin
            if (pos < pixels) begin
               if ($urandom_range(0, 11) == 0) send_req(1'b1, PIX_W'($urandom), 1'b0, 1'b0, '0);
               send_req(1'b0, PIX_W'($urandom), 1'b0, 1'b0, '0);
            end else begin
               if ($urandom_range(0, 7) == 0) send_req(1'b0, PIX_W'($urandom), 1'b0, 1'b0, '0);
               send_req(1'b1, PIX_W'($urandom), 1'b0, 1'b0, '0);
            end
         end
         // flushes after the frame has drained
         if (!cut) repeat ($urandom_range(0, 2)) send_req(1'b1, PIX_W'($urandom), 1'b0, 1'b0, '0);

         if (phase == 3) bulk_items += live_items - before_bulk;
         if (cut) frames_cut++;
         phase_done = !cut;
         frames++;
         phase++;
      end

      wait_idle();
      $display("ran %0d directed rows and %0d random frames (%0d cut short), %0d register writes",
               DIR_ROWS, frames, frames_cut, csr_writes);
      $display("%0d requests took effect, %0d results compared, %0d errors",
               live_items, results_seen, fail_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/bbr_pkg.sv
hw/rtl/bbr_ctrl.sv
hw/rtl/bbr_window.sv
hw/rtl/bbr_avg.sv
hw/rtl/box_blur_3x3_rgb_unit.sv
test/tb.sv
